// ----- hdl/jan_pkg.sv -----
// Shared types and constants of the joystick axis normalizer.
// Used by jan_axis, joystick_axis_normalizer and jan_check; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package jan_pkg;

    localparam int FS_W      = 10;
    localparam int VAL_W     = 11;
    localparam int OUT_W     = 40;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X   = 3'd0,
        CFG_CENTER_Y   = 3'd1,
        CFG_CENTER_Z   = 3'd2,
        CFG_NOISE_THR  = 3'd3,
        CFG_FULL_SCALE = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_DONE = 5'b10000
    } t_lane_state;

    typedef struct packed {
        logic start;
        logic ack;
    } t_lane_ctrl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_lane_stat;

endpackage

`default_nettype wire

// ----- hdl/jan_axis.sv -----
// One axis lane: noise gate, bit-serial multiply, restoring divide, clamp and dead zone.
// Depends on jan_pkg for the state, control and status types.
`timescale 1ns / 1ps
`default_nettype none

module jan_axis #(
    parameter int   SAMPLE_BITS = 12,
    parameter int   DEADZONE    = 3,
    parameter logic NEGATE      = 1'b0
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  jan_pkg::t_lane_ctrl              i_ctrl,
    input  wire        [SAMPLE_BITS-1:0]     i_raw,
    input  wire        [SAMPLE_BITS-1:0]     i_center,
    input  wire        [SAMPLE_BITS-1:0]     i_thresh,
    input  wire        [jan_pkg::FS_W-1:0]   i_full_scale,
    output jan_pkg::t_lane_stat              o_stat,
    output logic                             o_changed,
    output logic signed [jan_pkg::VAL_W-1:0] o_value
);

    localparam int NB    = SAMPLE_BITS + jan_pkg::FS_W;
    localparam int CNT_W = $clog2(NB);

    jan_pkg::t_lane_state r_state, n_state;
    logic [SAMPLE_BITS-1:0]   r_last, n_last;
    logic [SAMPLE_BITS-1:0]   r_mag, n_mag;
    logic                     r_neg, n_neg;
    logic [jan_pkg::FS_W-1:0] r_fs, n_fs;
    logic [NB-1:0]            r_acc, n_acc;
    logic [SAMPLE_BITS-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_changed, n_changed;
    logic [jan_pkg::VAL_W-1:0] r_value, n_value;

    logic [SAMPLE_BITS-1:0]   w_move;
    logic [SAMPLE_BITS:0]     w_rem_sh;
    logic                     w_qbit;
    logic [jan_pkg::FS_W-1:0] w_clip;
    logic [jan_pkg::FS_W-1:0] w_mag_out;
    logic [jan_pkg::VAL_W-1:0] w_signed;

    always_comb begin
        w_move   = (i_raw >= r_last) ? (i_raw - r_last) : (r_last - i_raw);
        w_rem_sh = {r_rem, r_acc[NB-1]};
        w_qbit   = (w_rem_sh >= {1'b0, i_center});
        if (r_acc > NB'(i_full_scale)) begin
            w_clip = i_full_scale;
        end else begin
            w_clip = r_acc[jan_pkg::FS_W-1:0];
        end
        if ((i_center == '0) || (w_clip < jan_pkg::FS_W'(DEADZONE))) begin
            w_mag_out = '0;
        end else begin
            w_mag_out = w_clip;
        end
        w_signed = r_neg ? (jan_pkg::VAL_W'(0) - {1'b0, w_mag_out}) : {1'b0, w_mag_out};
    end

    always_comb begin
        n_state   = r_state;
        n_last    = r_last;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_fs      = r_fs;
        n_acc     = r_acc;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_changed = r_changed;
        n_value   = r_value;
        case (r_state)
            jan_pkg::ST_IDLE: begin
                if (i_ctrl.start) begin
                    if (w_move > i_thresh) begin
                        n_last    = i_raw;
                        n_changed = 1'b1;
                        n_mag     = (i_raw >= i_center) ? (i_raw - i_center)
                                                        : (i_center - i_raw);
                        n_neg     = (i_raw < i_center) ^ NEGATE;
                        n_fs      = i_full_scale;
                        n_acc     = '0;
                        n_cnt     = CNT_W'(jan_pkg::FS_W - 1);
                        n_state   = jan_pkg::ST_MUL;
                    end else begin
                        n_changed = 1'b0;
                        n_value   = '0;
                        n_state   = jan_pkg::ST_DONE;
                    end
                end
            end
            jan_pkg::ST_MUL: begin
                n_acc = {r_acc[NB-2:0], 1'b0} + (r_fs[jan_pkg::FS_W-1] ? NB'(r_mag) : '0);
                n_fs  = {r_fs[jan_pkg::FS_W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_rem   = '0;
                    n_cnt   = CNT_W'(NB - 1);
                    n_state = jan_pkg::ST_DIV;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            jan_pkg::ST_DIV: begin
                if (w_qbit) begin
                    n_rem = SAMPLE_BITS'(w_rem_sh - {1'b0, i_center});
                end else begin
                    n_rem = w_rem_sh[SAMPLE_BITS-1:0];
                end
                n_acc = {r_acc[NB-2:0], w_qbit};
                if (r_cnt == '0) begin
                    n_state = jan_pkg::ST_FIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            jan_pkg::ST_FIN: begin
                n_value = w_signed;
                n_state = jan_pkg::ST_DONE;
            end
            jan_pkg::ST_DONE: begin
                if (i_ctrl.ack) begin
                    n_state = jan_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jan_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jan_pkg::ST_IDLE;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag     <= n_mag;
        r_neg     <= n_neg;
        r_fs      <= n_fs;
        r_acc     <= n_acc;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
        r_changed <= n_changed;
        r_value   <= n_value;
    end

    assign o_stat.idle = (r_state == jan_pkg::ST_IDLE);
    assign o_stat.done = (r_state == jan_pkg::ST_DONE);
    assign o_changed   = r_changed;
    assign o_value     = r_value;

endmodule

`default_nettype wire

// ----- hdl/joystick_axis_normalizer.sv -----
// Joystick axis normalizer: one request of three raw ADC samples gives one result with a
// changed flag and a normalized position per axis. For each axis that moves further than the
// noise threshold, its lane runs a bit-serial multiply by full_scale, one bit per cycle, then
// a restoring divide by the center, one quotient bit per cycle, then clamp and dead zone in
// its finish state; the output register is loaded once every lane is done. The three lanes
// run side by side. A lane whose axis does not move goes straight from idle to its done state.
// A new request is taken once the lanes have handed their result to the output register,
// which holds it until the downstream side takes it.
// Depends on jan_pkg and jan_axis.
`timescale 1ns / 1ps
`default_nettype none

module joystick_axis_normalizer #(
    parameter int SAMPLE_BITS = 12,
    parameter int DEADZONE    = 3,
    localparam int IN_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int CFG_W = (SAMPLE_BITS > jan_pkg::FS_W) ? SAMPLE_BITS : jan_pkg::FS_W
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // raw_x, raw_y, raw_z from bit 0 upward, zero padding on top.
    input  wire  [IN_W-1:0]                  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // changed_x, value_x, changed_y, value_y, changed_z, value_z from bit 0 upward.
    output logic [jan_pkg::OUT_W-1:0]        m_axis_tdata,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [jan_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [CFG_W-1:0]                 i_cfg_data
);

    logic [SAMPLE_BITS-1:0]   r_center_x, r_center_y, r_center_z, r_thresh;
    logic [jan_pkg::FS_W-1:0] r_full_scale;
    logic                     r_m_valid;
    logic [jan_pkg::OUT_W-1:0] r_m_data;

    jan_pkg::t_lane_ctrl w_ctrl;
    jan_pkg::t_lane_stat w_stat_x, w_stat_y, w_stat_z;
    logic w_chg_x, w_chg_y, w_chg_z;
    logic [jan_pkg::VAL_W-1:0] w_val_x, w_val_y, w_val_z;
    logic w_load;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = w_stat_x.idle & w_stat_y.idle & w_stat_z.idle;
    assign w_load        = w_stat_x.done & w_stat_y.done & w_stat_z.done
                           & (!r_m_valid | m_axis_tready);
    assign w_ctrl.start  = s_axis_tvalid & s_axis_tready;
    assign w_ctrl.ack    = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= SAMPLE_BITS'(2048);
            r_center_y   <= SAMPLE_BITS'(2048);
            r_center_z   <= SAMPLE_BITS'(2048);
            r_thresh     <= SAMPLE_BITS'(8);
            r_full_scale <= jan_pkg::FS_W'(100);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                jan_pkg::CFG_CENTER_X:   r_center_x   <= i_cfg_data[SAMPLE_BITS-1:0];
                jan_pkg::CFG_CENTER_Y:   r_center_y   <= i_cfg_data[SAMPLE_BITS-1:0];
                jan_pkg::CFG_CENTER_Z:   r_center_z   <= i_cfg_data[SAMPLE_BITS-1:0];
                jan_pkg::CFG_NOISE_THR:  r_thresh     <= i_cfg_data[SAMPLE_BITS-1:0];
                jan_pkg::CFG_FULL_SCALE: r_full_scale <= i_cfg_data[jan_pkg::FS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    jan_axis #(.SAMPLE_BITS(SAMPLE_BITS), .DEADZONE(DEADZONE), .NEGATE(1'b1)) u_axis_x (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_raw        (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_center     (r_center_x),
        .i_thresh     (r_thresh),
        .i_full_scale (r_full_scale),
        .o_stat       (w_stat_x),
        .o_changed    (w_chg_x),
        .o_value      (w_val_x)
    );

    jan_axis #(.SAMPLE_BITS(SAMPLE_BITS), .DEADZONE(DEADZONE), .NEGATE(1'b1)) u_axis_y (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_raw        (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_center     (r_center_y),
        .i_thresh     (r_thresh),
        .i_full_scale (r_full_scale),
        .o_stat       (w_stat_y),
        .o_changed    (w_chg_y),
        .o_value      (w_val_y)
    );

    jan_axis #(.SAMPLE_BITS(SAMPLE_BITS), .DEADZONE(DEADZONE), .NEGATE(1'b0)) u_axis_z (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_raw        (s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
        .i_center     (r_center_z),
        .i_thresh     (r_thresh),
        .i_full_scale (r_full_scale),
        .o_stat       (w_stat_z),
        .o_changed    (w_chg_z),
        .o_value      (w_val_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_data <= {4'b0000, w_val_z, w_chg_z, w_val_y, w_chg_y, w_val_x, w_chg_x};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

// ----- hdl/jan_check.sv -----
// Port-level checker for joystick_axis_normalizer, attached to it by the bind at the end.
// Depends on jan_pkg for the widths of the ports.
`timescale 1ns / 1ps
`default_nettype none

module jan_check (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           s_axis_tvalid,
    input wire                           s_axis_tready,
    input wire                           m_axis_tvalid,
    input wire                           m_axis_tready,
    input wire [jan_pkg::OUT_W-1:0]      m_axis_tdata
);

    // Only one request is in flight, so acceptance closes the input for the next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // A new result never appears right after a request is taken.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
        else $error("result appeared without processing time");

    // An axis that did not move reports a zero position.
    a_unchanged_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[0] || (m_axis_tdata[11:1] == 11'd0))
                        && (m_axis_tdata[12] || (m_axis_tdata[23:13] == 11'd0))
                        && (m_axis_tdata[24] || (m_axis_tdata[35:25] == 11'd0))))
        else $error("unchanged axis with nonzero value");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind joystick_axis_normalizer jan_check u_jan_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for joystick_axis_normalizer: directed and random sample requests with
// randomly stalled stream sides, each result checked against a built-in axis predictor.
// Depends on jan_pkg and the joystick_axis_normalizer RTL only.
`timescale 1ns / 1ps

module tb;

    localparam int SAMPLE_W        = 12;
    localparam int AXIS_STRIDE     = 1 + jan_pkg::VAL_W;
    localparam int DEADZONE_LIM    = 3;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_ITEMS     = 128;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT  = 3000;

    localparam logic [jan_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd5;
    localparam logic [jan_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd6;
    localparam logic [jan_pkg::CFG_IDX_W-1:0] CFG_SPARE_C = 3'd7;

    typedef struct packed {
        logic [2:0]                     changed;
        logic [2:0][jan_pkg::VAL_W-1:0] value;
    } t_joy_position;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [39:0]                     s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [jan_pkg::OUT_W-1:0]       m_axis_tdata;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [jan_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [SAMPLE_W-1:0]             i_cfg_data = '0;

    logic [2:0][SAMPLE_W-1:0]     center_reg = {3{12'd2048}};
    logic [SAMPLE_W-1:0]          noise_reg  = 12'd8;
    logic [jan_pkg::FS_W-1:0]     scale_reg  = 10'd100;
    logic [2:0][SAMPLE_W-1:0]     last_raw   = '0;

    t_joy_position pending_positions[$];
    int            failures = 0;
    int            idle_cycles = 0;
    bit            tx_steady = 1'b0;
    bit            rx_steady = 1'b0;
    bit            rx_hold_req = 1'b0;
    bit            rx_holding = 1'b0;
    string         axis_name [3] = '{"x", "y", "z"};

    joystick_axis_normalizer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_joy_position normalize_sample(input logic [2:0][SAMPLE_W-1:0] raw);
        t_joy_position r;
        longint        diff;
        longint        pos;
        longint        lim;
        lim = longint'(scale_reg);
        for (int a = 0; a < 3; a++) begin
            r.changed[a] = 1'b0;
            r.value[a] = '0;
            diff = longint'(raw[a]) - longint'(last_raw[a]);
            if (diff < 0) diff = -diff;
            if (diff > longint'(noise_reg)) begin
                last_raw[a] = raw[a];
                r.changed[a] = 1'b1;
                if (center_reg[a] == '0) begin
                    pos = 0;
                end else begin
                    pos = (longint'(raw[a]) - longint'(center_reg[a])) * lim
                          / longint'(center_reg[a]);
                end
                if (pos > lim) pos = lim;
                if (pos < -lim) pos = -lim;
                if (pos > -DEADZONE_LIM && pos < DEADZONE_LIM) pos = 0;
                if (a < 2) pos = -pos;
                r.value[a] = pos[jan_pkg::VAL_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_raw(input int a);
        int sel;
        int v;
        int step;
        sel = $urandom_range(99);
        if (sel < 40) begin
            v = $urandom_range(4095);
        end else if (sel < 65) begin
            step = int'(noise_reg) + int'($urandom_range(3)) - 1;
            if ($urandom_range(1)) step = -step;
            v = int'(last_raw[a]) + step;
        end else if (sel < 80) begin
            v = int'(center_reg[a]) + int'($urandom_range(160)) - 80;
        end else if (sel < 90) begin
            v = $urandom_range(1) ? 4095 : 0;
        end else begin
            v = int'(last_raw[a]);
        end
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_center();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) return '0;
        if (sel < 20) return 12'hFFF;
        if (sel < 30) return 12'd1;
        if (sel < 70) return 12'($urandom_range(1024, 3072));
        return 12'($urandom_range(4095));
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_sample(input logic [SAMPLE_W-1:0] x, y, z);
        while (!tx_steady && $urandom_range(99) < 32) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, z, y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_positions.push_back(normalize_sample({z, y, x}));
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (pending_positions.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [jan_pkg::CFG_IDX_W-1:0] idx,
                             input logic [SAMPLE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            jan_pkg::CFG_CENTER_X:   center_reg[0] = data;
            jan_pkg::CFG_CENTER_Y:   center_reg[1] = data;
            jan_pkg::CFG_CENTER_Z:   center_reg[2] = data;
            jan_pkg::CFG_NOISE_THR:  noise_reg = data;
            jan_pkg::CFG_FULL_SCALE: scale_reg = data[jan_pkg::FS_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Reset settings: full deflection both ways, the dead zone edge and the noise edge.
    task automatic test_reset_config();
        send_sample(12'd0, 12'd0, 12'd0);
        send_sample(12'hFFF, 12'hFFF, 12'hFFF);
        send_sample(12'd0, 12'd0, 12'd0);
        send_sample(12'd2100, 12'd2110, 12'd2048);
        send_sample(12'd2108, 12'd2119, 12'd2057);
        send_sample(12'd1996, 12'd1986, 12'd2039);
    endtask

    // Zero and extreme centers, masked and zero full scale, thresholds at both ends.
    task automatic test_register_extremes();
        wait_all_results();
        write_reg(jan_pkg::CFG_CENTER_X, 12'd0);
        write_reg(jan_pkg::CFG_CENTER_Y, 12'd0);
        write_reg(jan_pkg::CFG_CENTER_Z, 12'd0);
        send_sample(12'hFFF, 12'd100, 12'd0);
        wait_all_results();
        write_reg(jan_pkg::CFG_CENTER_X, 12'hFFF);
        write_reg(jan_pkg::CFG_CENTER_Y, 12'd1);
        write_reg(jan_pkg::CFG_CENTER_Z, 12'hFFF);
        write_reg(jan_pkg::CFG_FULL_SCALE, 12'hFFF);
        write_reg(jan_pkg::CFG_NOISE_THR, 12'd0);
        send_sample(12'd0, 12'hFFF, 12'hFFE);
        send_sample(12'd1, 12'hFFE, 12'hFFE);
        wait_all_results();
        write_reg(jan_pkg::CFG_FULL_SCALE, 12'h400);
        send_sample(12'hFFF, 12'd0, 12'd0);
        wait_all_results();
        write_reg(jan_pkg::CFG_FULL_SCALE, 12'd1000);
        write_reg(jan_pkg::CFG_CENTER_X, 12'd2048);
        write_reg(jan_pkg::CFG_CENTER_Y, 12'd2048);
        write_reg(jan_pkg::CFG_CENTER_Z, 12'd2048);
        write_reg(jan_pkg::CFG_NOISE_THR, 12'hFFF);
        send_sample(12'd0, 12'hFFF, 12'd2048);
        wait_all_results();
        write_reg(jan_pkg::CFG_NOISE_THR, 12'd8);
        write_reg(jan_pkg::CFG_FULL_SCALE, 12'd1);
        send_sample(12'hFFF, 12'd0, 12'hFFF);
    endtask

    // Writes to unused register indexes must leave every setting untouched.
    task automatic test_unknown_index();
        wait_all_results();
        write_reg(jan_pkg::CFG_FULL_SCALE, 12'd100);
        write_reg(CFG_SPARE_A, 12'd0);
        write_reg(CFG_SPARE_B, 12'd0);
        write_reg(CFG_SPARE_C, 12'd0);
        send_sample(12'd3000, 12'd1000, 12'd4000);
    endtask

    // The receiver holds off for a long time while requests keep coming.
    task automatic test_output_backpressure();
        wait_all_results();
        rx_hold_req = 1'b1;
        while (!rx_holding) @(negedge i_clk);
        tx_steady = 1'b1;
        repeat (8) send_sample(pick_raw(0), pick_raw(1), pick_raw(2));
        tx_steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [jan_pkg::FS_W-1:0] scale;
        int                       sel;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_all_results();
            write_reg(jan_pkg::CFG_CENTER_X, pick_center());
            write_reg(jan_pkg::CFG_CENTER_Y, pick_center());
            write_reg(jan_pkg::CFG_CENTER_Z, pick_center());
            sel = $urandom_range(99);
            if (sel < 15) write_reg(jan_pkg::CFG_NOISE_THR, 12'd0);
            else if (sel < 20) write_reg(jan_pkg::CFG_NOISE_THR, 12'hFFF);
            else if (sel < 30) write_reg(jan_pkg::CFG_NOISE_THR, 12'($urandom_range(4095)));
            else write_reg(jan_pkg::CFG_NOISE_THR, 12'($urandom_range(40)));
            sel = $urandom_range(99);
            if (sel < 10) scale = 10'd0;
            else if (sel < 20) scale = 10'd1;
            else if (sel < 30) scale = 10'd1023;
            else if (sel < 40) scale = 10'd1000;
            else if (sel < 50) scale = 10'($urandom_range(1001, 1023));
            else scale = 10'($urandom_range(1, 1000));
            // Upper data bits are random: the block keeps only the low ten.
            write_reg(jan_pkg::CFG_FULL_SCALE, {2'($urandom_range(3)), scale});
            tx_steady = (p == 5);
            rx_steady = (p == 5);
            repeat (PHASE_ITEMS) send_sample(pick_raw(0), pick_raw(1), pick_raw(2));
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_holding = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_holding = 1'b0;
            end
            m_axis_tready <= rx_steady || ($urandom_range(99) >= 32);
        end
    end

    always @(posedge i_clk) begin
        t_joy_position             want;
        logic                      got_chg;
        logic [jan_pkg::VAL_W-1:0] got_val;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_positions.size() == 0) begin
                $error("result with no request pending: %h", m_axis_tdata);
                failures++;
            end else begin
                want = pending_positions.pop_front();
                for (int a = 0; a < 3; a++) begin
                    got_chg = m_axis_tdata[a*AXIS_STRIDE];
                    got_val = m_axis_tdata[a*AXIS_STRIDE+1 +: jan_pkg::VAL_W];
                    if (got_chg !== want.changed[a]) begin
                        $error("%s: expected %0d, got %0d", {"changed_", axis_name[a]},
                               want.changed[a], got_chg);
                        failures++;
                    end
                    if (got_val !== want.value[a]) begin
                        $error("%s: expected %0d, got %0d", {"value_", axis_name[a]},
                               $signed(want.value[a]), $signed(got_val));
                        failures++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_config();
        test_register_extremes();
        test_unknown_index();
        test_output_backpressure();
        test_random_traffic();
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
